// File: rtl/swr_pkg.sv
`default_nettype none
package swr_pkg;

    localparam int POOL_DEPTH  = 1024;
    localparam int IDX_W       = $clog2(POOL_DEPTH);
    localparam int CNT_W       = 11;
    localparam int SIZE_W      = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam int WORD_W      = 31;
    localparam int VAL_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int EPOCH_W     = 8;
    localparam int MEM_W       = EPOCH_W + IDX_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COUNT = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0] POOL_SIZE_RST  = CNT_W'(1024);
    localparam logic [CNT_W-1:0] DRAW_COUNT_RST = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};

    // one classified draw, handed from front to back
    typedef struct packed {
        logic             new_set;
        logic             exhausted;
        logic             last;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] tail;
    } t_cmd;

endpackage
`default_nettype wire

// File: rtl/swr_in_if.sv
`default_nettype none
interface swr_in_if;
    logic                      valid;
    logic                      ready;
    logic                      new_set;
    logic [swr_pkg::WORD_W-1:0] random_word;

    modport source (output valid, output new_set, output random_word, input ready);
    modport sink (input valid, input new_set, input random_word, output ready);
endinterface
`default_nettype wire

// File: rtl/swr_out_if.sv
`default_nettype none
interface swr_out_if;
    logic                      valid;
    logic                      ready;
    logic [swr_pkg::VAL_W-1:0] drawn_value;
    logic                      last_of_set;
    logic                      exhausted;

    modport source (output valid, output drawn_value, output last_of_set, output exhausted,
                    input ready);
    modport sink (input valid, input drawn_value, input last_of_set, input exhausted,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/swr_cfg_if.sv
`default_nettype none
interface swr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [swr_pkg::CFG_IDX_W-1:0] index;
    logic [swr_pkg::CNT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/sample_without_replacement_unit.sv
// channel   | dir | handshake     | payload
// i_item    | in  | valid / ready | new_set, random_word[30:0]
// o_result  | out | valid / ready | drawn_value[9:0], last_of_set, exhausted
// i_cfg     | in  | valid / ready | index[1:0], data[10:0] (0 pool_size, 1 draw_count)
//
// a draw steps through the back-end states pop, read index, read tail, move and output,
// one at a time because of the single pool memory port; an exhausted draw skips to output
// after reset a clearing pass over all 1024 entries runs with i_item.ready low; cfg is always ready
// each 255th new set reruns the clearing pass when the epoch tag wraps
// a two-entry queue and an output register let input and output stall independently
`default_nettype none
module sample_without_replacement_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    swr_in_if.sink    i_item,
    swr_cfg_if.sink   i_cfg,
    swr_out_if.source o_result
);

    logic                          push;
    logic                          pop;
    logic                          full;
    logic                          empty;
    logic                          enable;
    swr_pkg::t_cmd                 front_cmd;
    swr_pkg::t_cmd                 queue_cmd;
    logic                          ram_we;
    logic [swr_pkg::IDX_W-1:0]     ram_addr;
    logic [swr_pkg::MEM_W-1:0]     ram_wdata;
    logic [swr_pkg::MEM_W-1:0]     ram_rdata;

    swr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cfg    (i_cfg),
        .i_enable (enable),
        .i_full   (full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    swr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    swr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_enable    (enable),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_result    (o_result)
    );

    swr_ram #(
        .WIDTH (swr_pkg::MEM_W),
        .DEPTH (swr_pkg::POOL_DEPTH)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// File: rtl/swr_ram.sv
`default_nettype none
module swr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

// File: rtl/swr_front.sv
`default_nettype none
module swr_front (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    swr_in_if.sink       i_item,
    swr_cfg_if.sink      i_cfg,
    input  wire logic    i_enable,
    input  wire logic    i_full,
    output logic         o_push,
    output swr_pkg::t_cmd o_cmd
);

    logic [swr_pkg::CNT_W-1:0]  r_pool_size;
    logic [swr_pkg::CNT_W-1:0]  r_draw_count;
    logic [swr_pkg::CNT_W-1:0]  r_draws_done;
    logic                       r_s1_vld;
    logic                       r_s1_new_set;
    logic                       r_s1_exh;
    logic                       r_s1_last;
    logic [swr_pkg::WORD_W-1:0] r_s1_word;
    logic [swr_pkg::SIZE_W-1:0] r_s1_rem;

    logic [swr_pkg::SIZE_W-1:0] size;
    logic [swr_pkg::CNT_W-1:0]  dd;
    logic [swr_pkg::CNT_W-1:0]  n_draws_done;
    logic                       exh;
    logic [swr_pkg::SIZE_W-1:0] rem;
    logic                       last;
    logic                       accept;
    logic [swr_pkg::WORD_W+swr_pkg::SIZE_W-1:0] prod;
    logic [swr_pkg::SIZE_W-1:0] k_full;
    logic [swr_pkg::SIZE_W-1:0] tail_full;

    assign i_cfg.ready = 1'b1;

    // saturate the pool size to the memory depth
    assign size = (swr_pkg::SIZE_W'(r_pool_size) > swr_pkg::SIZE_W'(swr_pkg::POOL_DEPTH))
                  ? swr_pkg::SIZE_W'(swr_pkg::POOL_DEPTH) : swr_pkg::SIZE_W'(r_pool_size);
    assign dd   = i_item.new_set ? '0 : r_draws_done;
    assign exh  = swr_pkg::SIZE_W'(dd) >= size;
    assign rem  = size - swr_pkg::SIZE_W'(dd);
    assign n_draws_done = (dd != swr_pkg::CNT_MAX) ? dd + swr_pkg::CNT_W'(1) : dd;
    assign last = n_draws_done == r_draw_count;

    assign o_push       = r_s1_vld && !i_full;
    assign i_item.ready = i_enable && (!r_s1_vld || o_push);
    assign accept       = i_item.valid && i_item.ready;

    // scale the random word to an index below the remaining count
    assign prod      = {{swr_pkg::SIZE_W{1'b0}}, r_s1_word}
                     * {{swr_pkg::WORD_W{1'b0}}, r_s1_rem};
    assign k_full    = prod[swr_pkg::WORD_W+swr_pkg::SIZE_W-1:swr_pkg::WORD_W];
    assign tail_full = r_s1_rem - swr_pkg::SIZE_W'(1);

    always_comb begin
        o_cmd.new_set   = r_s1_new_set;
        o_cmd.exhausted = r_s1_exh;
        o_cmd.last      = r_s1_last;
        o_cmd.k         = k_full[swr_pkg::IDX_W-1:0];
        o_cmd.tail      = tail_full[swr_pkg::IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size  <= swr_pkg::POOL_SIZE_RST;
            r_draw_count <= swr_pkg::DRAW_COUNT_RST;
            r_draws_done <= '0;
            r_s1_vld     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    swr_pkg::REG_POOL_SIZE:  r_pool_size  <= i_cfg.data;
                    swr_pkg::REG_DRAW_COUNT: r_draw_count <= i_cfg.data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_draws_done <= n_draws_done;
                r_s1_vld     <= 1'b1;
            end else if (o_push) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_new_set <= i_item.new_set;
            r_s1_exh     <= exh;
            r_s1_last    <= last;
            r_s1_word    <= i_item.random_word;
            r_s1_rem     <= rem;
        end
    end

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted transfer did not reach the classify stage");

endmodule
`default_nettype wire

// File: rtl/swr_queue.sv
`default_nettype none
module swr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire swr_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output swr_pkg::t_cmd      o_cmd
);

    swr_pkg::t_cmd               r_mem [swr_pkg::QUEUE_DEPTH];
    logic [swr_pkg::QPTR_W-1:0]  r_wp;
    logic [swr_pkg::QPTR_W-1:0]  r_rp;
    logic [swr_pkg::QCNT_W-1:0]  r_cnt;

    assign o_full  = r_cnt == swr_pkg::QCNT_W'(swr_pkg::QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == swr_pkg::QPTR_W'(swr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wp + swr_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == swr_pkg::QPTR_W'(swr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rp + swr_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + swr_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - swr_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue popped while empty");

endmodule
`default_nettype wire

// File: rtl/swr_back.sv
`default_nettype none
module swr_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_empty,
    input  wire swr_pkg::t_cmd               i_cmd,
    output logic                             o_pop,
    output logic                             o_enable,
    output logic                             o_ram_we,
    output logic [swr_pkg::IDX_W-1:0]        o_ram_addr,
    output logic [swr_pkg::MEM_W-1:0]        o_ram_wdata,
    input  wire logic [swr_pkg::MEM_W-1:0]   i_ram_rdata,
    swr_out_if.source                        o_result
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SWEEP = 6'b000010,
        S_RDK   = 6'b000100,
        S_RDT   = 6'b001000,
        S_WR    = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                       r_state, n_state;
    swr_pkg::t_cmd                r_cmd;
    logic [swr_pkg::EPOCH_W-1:0]  r_epoch, n_epoch;
    logic [swr_pkg::IDX_W-1:0]    r_sweep;
    logic [swr_pkg::IDX_W-1:0]    r_val;
    logic                         r_init_done;
    logic                         r_out_vld;
    logic [swr_pkg::VAL_W-1:0]    r_out_val;
    logic                         r_out_last;
    logic                         r_out_exh;

    logic [swr_pkg::EPOCH_W-1:0]  rd_tag;
    logic [swr_pkg::IDX_W-1:0]    rd_ent;
    logic                         rd_hit;
    logic                         sweep_end;
    logic                         load_out;
    logic                         wrap;

    // an entry counts as written only when its tag matches the current epoch
    assign rd_tag    = i_ram_rdata[swr_pkg::MEM_W-1:swr_pkg::IDX_W];
    assign rd_ent    = i_ram_rdata[swr_pkg::IDX_W-1:0];
    assign rd_hit    = rd_tag == r_epoch;
    assign sweep_end = r_sweep == swr_pkg::IDX_W'(swr_pkg::POOL_DEPTH - 1);
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign o_enable  = r_init_done;
    assign load_out  = (r_state == S_OUT) && (!r_out_vld || o_result.ready);
    assign wrap      = r_epoch == {swr_pkg::EPOCH_W{1'b1}};

    assign o_result.valid       = r_out_vld;
    assign o_result.drawn_value = r_out_val;
    assign o_result.last_of_set = r_out_last;
    assign o_result.exhausted   = r_out_exh;

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_addr  = r_cmd.k;
        o_ram_wdata = {r_epoch, rd_hit ? rd_ent : r_cmd.tail};
        case (r_state)
            S_SWEEP: begin
                o_ram_we    = 1'b1;
                o_ram_addr  = r_sweep;
                o_ram_wdata = '0;
            end
            S_RDT: o_ram_addr = r_cmd.tail;
            S_WR:  o_ram_we   = r_cmd.k != r_cmd.tail;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_epoch = r_epoch;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.new_set && wrap) begin
                        n_epoch = swr_pkg::EPOCH_W'(1);
                        n_state = S_SWEEP;
                    end else begin
                        if (i_cmd.new_set) begin
                            n_epoch = r_epoch + swr_pkg::EPOCH_W'(1);
                        end
                        n_state = i_cmd.exhausted ? S_OUT : S_RDK;
                    end
                end
            end
            S_SWEEP: begin
                if (sweep_end) begin
                    if (!r_init_done) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = r_cmd.exhausted ? S_OUT : S_RDK;
                    end
                end
            end
            S_RDK: n_state = S_RDT;
            S_RDT: n_state = S_WR;
            S_WR:  n_state = S_OUT;
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_epoch     <= swr_pkg::EPOCH_W'(1);
            r_sweep     <= '0;
            r_init_done <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_epoch <= n_epoch;
            if (r_state == S_SWEEP) begin
                r_sweep <= sweep_end ? '0 : r_sweep + swr_pkg::IDX_W'(1);
                if (sweep_end) begin
                    r_init_done <= 1'b1;
                end
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_val <= '0;
        end else if (r_state == S_RDT) begin
            r_val <= rd_hit ? rd_ent : r_cmd.k;
        end
        if (load_out) begin
            r_out_val  <= swr_pkg::VAL_W'(r_val);
            r_out_last <= r_cmd.last;
            r_out_exh  <= r_cmd.exhausted;
        end
    end

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_state == S_SWEEP || r_state == S_WR))
        else $error("pool memory written outside sweep or move");

    a_exhausted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.exhausted) |-> (o_result.drawn_value == '0))
        else $error("exhausted result carries a nonzero value");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE))
        else $error("command popped but back end stayed idle");

endmodule
`default_nettype wire

// File: dv/tb_sample_without_replacement_unit.sv
`timescale 1ns / 1ps
module tb_sample_without_replacement_unit;

    localparam logic [swr_pkg::CFG_IDX_W-1:0] REG_SPARE_A = swr_pkg::CFG_IDX_W'(2);
    localparam logic [swr_pkg::CFG_IDX_W-1:0] REG_SPARE_B = swr_pkg::CFG_IDX_W'(3);
    localparam logic [swr_pkg::WORD_W-1:0]    WORD_MAX    = {swr_pkg::WORD_W{1'b1}};
    localparam int unsigned                   QUIET_LIMIT = 4096;

    typedef struct packed {
        logic [swr_pkg::VAL_W-1:0] drawn_value;
        logic                      last_of_set;
        logic                      exhausted;
    } t_draw;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swr_in_if  item_if ();
    swr_cfg_if cfg_if ();
    swr_out_if res_if ();

    sample_without_replacement_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the shuffle state
    logic [swr_pkg::VAL_W-1:0] pool_mem [swr_pkg::POOL_DEPTH];
    bit                        entry_live [swr_pkg::POOL_DEPTH];
    logic [swr_pkg::CNT_W-1:0] size_reg;
    logic [swr_pkg::CNT_W-1:0] count_reg;
    logic [swr_pkg::CNT_W-1:0] set_draws;

    t_draw       pending_draws [$];
    int unsigned mismatch_count = 0;
    int unsigned draws_seen = 0;
    int unsigned quiet_cycles = 0;
    bit          idle_on = 1'b1;

    task automatic flag_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
        $display("mismatch on draw %0d: %s got %0d want %0d", draws_seen, field, got, want);
        mismatch_count++;
    endtask

    function automatic logic [swr_pkg::VAL_W-1:0] slot_value(input int unsigned idx);
        return entry_live[idx] ? pool_mem[idx] : swr_pkg::VAL_W'(idx);
    endfunction

    function automatic void shuffle_draw(input logic new_set,
                                         input logic [swr_pkg::WORD_W-1:0] word);
        int unsigned      eff_size;
        int unsigned      remaining;
        int unsigned      k;
        int unsigned      tail;
        longint unsigned  prod;
        t_draw            d;
        d = '0;
        if (new_set) begin
            foreach (entry_live[i]) entry_live[i] = 1'b0;
            set_draws = '0;
        end
        eff_size = (size_reg > swr_pkg::POOL_DEPTH) ? swr_pkg::POOL_DEPTH : size_reg;
        if (set_draws >= eff_size) begin
            d.exhausted = 1'b1;
        end else begin
            remaining = eff_size - set_draws;
            prod = 64'(word) * 64'(remaining);
            k = int'(prod >> 31);
            tail = remaining - 1;
            d.drawn_value = slot_value(k);
            // swap the last live entry into the hole
            if (k != tail) begin
                pool_mem[k] = slot_value(tail);
                entry_live[k] = 1'b1;
            end
        end
        if (set_draws != swr_pkg::CNT_MAX)
            set_draws++;
        d.last_of_set = (set_draws == count_reg);
        pending_draws.push_back(d);
    endfunction

    function automatic logic [swr_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return WORD_MAX;
            2: return WORD_MAX - swr_pkg::WORD_W'($urandom_range(0, 255));
            default: return swr_pkg::WORD_W'($urandom());
        endcase
    endfunction

    task automatic send_draw(input logic new_set, input logic [swr_pkg::WORD_W-1:0] word);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        cfg_if.valid <= 1'b0;
        if (gap != 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.new_set     <= new_set;
        item_if.random_word <= word;
        do @(posedge i_clk); while (!(item_if.valid && item_if.ready));
        shuffle_draw(new_set, word);
    endtask

    // stop feeding and let every outstanding draw come back
    task automatic quiesce();
        item_if.valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [swr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swr_pkg::CNT_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        if (idx == swr_pkg::REG_POOL_SIZE)
            size_reg = val;
        else if (idx == swr_pkg::REG_DRAW_COUNT)
            count_reg = val;
    endtask

    task automatic set_config(input int unsigned pool, input int unsigned count);
        quiesce();
        write_reg(swr_pkg::REG_POOL_SIZE, swr_pkg::CNT_W'(pool));
        write_reg(swr_pkg::REG_DRAW_COUNT, swr_pkg::CNT_W'(count));
    endtask

    task automatic test_after_reset();
        send_draw(1'b0, '0);
        send_draw(1'b0, WORD_MAX);
        send_draw(1'b1, swr_pkg::WORD_W'(32'h4000_0000));
    endtask

    task automatic test_pool_extremes();
        set_config(1, 1);
        send_draw(1'b1, WORD_MAX);
        send_draw(1'b0, pick_word());
        set_config(0, 0);
        send_draw(1'b1, pick_word());
        send_draw(1'b0, pick_word());
        // above the depth the pool saturates
        set_config(swr_pkg::CNT_MAX, swr_pkg::CNT_MAX);
        send_draw(1'b1, WORD_MAX);
        send_draw(1'b0, '0);
    endtask

    task automatic test_spare_registers();
        set_config(4, 4);
        write_reg(REG_SPARE_A, swr_pkg::CNT_MAX);
        write_reg(REG_SPARE_B, swr_pkg::CNT_MAX);
        send_draw(1'b1, pick_word());
        send_draw(1'b0, pick_word());
    endtask

    task automatic test_resize_mid_set();
        set_config(16, 16);
        send_draw(1'b1, pick_word());
        repeat (3) send_draw(1'b0, pick_word());
        set_config(3, 16);
        send_draw(1'b0, pick_word());
        set_config(20, 16);
        send_draw(1'b0, WORD_MAX);
        send_draw(1'b0, pick_word());
    endtask

    task automatic test_full_shuffle();
        set_config(5, 5);
        send_draw(1'b1, pick_word());
        repeat (5) send_draw(1'b0, pick_word());
    endtask

    // enough new sets to wrap the clearing tag
    task automatic test_tag_wrap();
        set_config(swr_pkg::POOL_DEPTH, 1);
        idle_on = 1'b0;
        repeat (300) send_draw(1'b1, pick_word());
        idle_on = 1'b1;
    endtask

    // exhausted draws still advance the set counter up to the last mark
    task automatic test_exhausted_count();
        set_config(2, 30);
        idle_on = 1'b0;
        send_draw(1'b1, pick_word());
        repeat (39) send_draw(1'b0, pick_word());
        idle_on = 1'b1;
    endtask

    task automatic test_random_sets(input int unsigned budget);
        int unsigned sent;
        int unsigned pool;
        int unsigned count;
        int unsigned n_sets;
        int unsigned len;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(0, 9))
                0: pool = 0;
                1: pool = $urandom_range(swr_pkg::POOL_DEPTH + 1, swr_pkg::CNT_MAX);
                2: pool = swr_pkg::POOL_DEPTH;
                3: pool = $urandom_range(17, swr_pkg::POOL_DEPTH - 1);
                default: pool = $urandom_range(1, 16);
            endcase
            case ($urandom_range(0, 7))
                0: count = 0;
                1: count = swr_pkg::CNT_MAX;
                2: count = $urandom_range(1, 24);
                default: count = (pool >= 1 && pool <= 16) ? pool : $urandom_range(1, 16);
            endcase
            set_config(pool, count);
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          swr_pkg::CNT_W'($urandom()));
            idle_on = ($urandom_range(0, 3) != 0);
            n_sets = $urandom_range(1, 6);
            repeat (n_sets) begin
                len = (count >= 1 && count <= 24) ? count : $urandom_range(1, 12);
                case ($urandom_range(0, 7))
                    0: len = len + $urandom_range(1, 3);
                    1: len = $urandom_range(1, len);
                    default: ;
                endcase
                send_draw($urandom_range(0, 9) != 0, pick_word());
                repeat (len - 1) send_draw($urandom_range(0, 29) == 0, pick_word());
                sent += len;
            end
        end
        idle_on = 1'b1;
    endtask

    // result side: random back-pressure and in-order compare
    initial begin : result_sink
        int unsigned stall;
        t_draw       want;
        stall = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                draws_seen++;
                if (pending_draws.size() == 0) begin
                    flag_mismatch("transfer with nothing pending", res_if.drawn_value, 0);
                end else begin
                    want = pending_draws.pop_front();
                    if (res_if.drawn_value !== want.drawn_value)
                        flag_mismatch("drawn_value", res_if.drawn_value, want.drawn_value);
                    if (res_if.last_of_set !== want.last_of_set)
                        flag_mismatch("last_of_set", res_if.last_of_set, want.last_of_set);
                    if (res_if.exhausted !== want.exhausted)
                        flag_mismatch("exhausted", res_if.exhausted, want.exhausted);
                end
                stall = idle_on ? $urandom_range(0, 19) : 0;
            end else if (stall != 0) begin
                stall--;
            end
            if (i_rst_n)
                res_if.ready <= (stall == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        item_if.valid       <= 1'b0;
        item_if.new_set     <= 1'b0;
        item_if.random_word <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= swr_pkg::REG_POOL_SIZE;
        cfg_if.data         <= '0;
        i_rst_n             <= 1'b0;
        size_reg  = swr_pkg::POOL_SIZE_RST;
        count_reg = swr_pkg::DRAW_COUNT_RST;
        set_draws = '0;
        foreach (entry_live[i]) entry_live[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_pool_extremes();
        test_spare_registers();
        test_resize_mid_set();
        test_full_shuffle();
        test_tag_wrap();
        test_exhausted_count();
        test_random_sets(1180);

        quiesce();
        repeat (32) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
